[src/sfca_pkg.sv]
package sfca_pkg;

    localparam int KeyWidth = 64;
    localparam logic [KeyWidth-1:0] KeyUpperReset = 64'hAABBCCDDEEFFFFEE;
    localparam logic [KeyWidth-1:0] KeyLowerReset = 64'hDDCCBBAAAABBCCDD;
    localparam logic [7:0] CrcPoly = 8'h07;
    localparam logic [7:0] FrameLen = 8'h02;
    localparam int NumRounds = 10;

    localparam logic CfgKeyUpper = 1'b0;
    localparam logic CfgKeyLower = 1'b1;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] sample;
    } src_item_t;

    typedef struct packed {
        logic [63:0] cipher_upper;
        logic [63:0] cipher_lower;
    } dst_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[src/sample_framer_crc8_aes128_top.sv]
// Frames one sample per request (opcode, length, big-endian value, CRC-8, zero pad) and
// encrypts it with AES-128 under the key in registers 0/1. Fully pipelined: one request
// per cycle while the output is not stalled, 11 register stages (frame/whitening stage
// plus one stage per AES round, round keys expanded alongside each request). A stalled
// valid output freezes the whole pipeline.
module sample_framer_crc8_aes128_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  sfca_pkg::src_item_t   src_data,
    output logic                  dst_valid,
    input  logic                  dst_stall,
    output sfca_pkg::dst_item_t   dst_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [63:0]           cfg_wdata
);
    import sfca_pkg::*;

    logic [63:0]  key_upper_reg;
    logic [63:0]  key_lower_reg;
    logic         adv;
    logic [127:0] frame;
    logic [7:0]   crc;
    logic         s0_valid_reg;
    logic [127:0] s0_state_reg;
    logic [127:0] s0_key_reg;

    logic         st_valid [NumRounds+1];
    logic [127:0] st_state [NumRounds+1];
    logic [127:0] st_key   [NumRounds+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= KeyUpperReset;
            key_lower_reg <= KeyLowerReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgKeyUpper: key_upper_reg <= cfg_wdata;
                CfgKeyLower: key_lower_reg <= cfg_wdata;
                default:     key_upper_reg <= key_upper_reg;
            endcase
        end
    end

    assign adv       = !(dst_valid && dst_stall);
    assign src_stall = !adv;

    always_comb
    begin
        logic [7:0] op;
        op  = 8'(src_data.channel) + 8'd1;
        crc = crc8_byte(8'h00, op);
        crc = crc8_byte(crc, FrameLen);
        crc = crc8_byte(crc, src_data.sample[15:8]);
        crc = crc8_byte(crc, src_data.sample[7:0]);
        frame = {op, FrameLen, src_data.sample, crc, 88'h0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_state_reg <= frame ^ {key_upper_reg, key_lower_reg};
            s0_key_reg   <= {key_upper_reg, key_lower_reg};
        end
    end

    assign st_valid[0] = s0_valid_reg;
    assign st_state[0] = s0_state_reg;
    assign st_key[0]   = s0_key_reg;

    for (genvar r = 1; r <= NumRounds; r++)
    begin : g_round
        sfca_round #(.ROUND(r)) u_round (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .prev_valid  (st_valid[r-1]),
            .prev_state  (st_state[r-1]),
            .prev_key    (st_key[r-1]),
            .stage_valid (st_valid[r]),
            .stage_state (st_state[r]),
            .stage_key   (st_key[r])
        );
    end

    assign dst_valid = st_valid[NumRounds];
    assign dst_data  = dst_item_t'(st_state[NumRounds]);

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid)
        else $error("input stalled with empty output stage");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s0_valid_reg) && $stable(st_valid[NumRounds/2]))
        else $error("pipeline moved during stall");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && st_valid[NumRounds-1] |=> dst_valid)
        else $error("request lost in last stage");
`endif

endmodule

[src/sfca_round.sv]
module sfca_round #(
    parameter int ROUND = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         prev_valid,
    input  logic [127:0] prev_state,
    input  logic [127:0] prev_key,
    output logic         stage_valid,
    output logic [127:0] stage_state,
    output logic [127:0] stage_key
);
    import sfca_pkg::*;

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] key_reg;
    logic [127:0] state_next;
    logic [127:0] key_next;

    // key schedule step, one word group per stage
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, t;
        w0 = prev_key[127:96];
        w1 = prev_key[95:64];
        w2 = prev_key[63:32];
        w3 = prev_key[31:0];
        t = {SBOX[w3[23:16]] ^ rcon(4'(ROUND)), SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_next = {w0, w1, w2, w3};
    end

    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = prev_state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
            end
        end
        if (ROUND != NumRounds)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            state_next[127 - 8*i -: 8] = t[i] ^ key_next[127 - 8*i -: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_state = state_reg;
    assign stage_key   = key_reg;

endmodule

[test/sfca_checker.sv]
module sfca_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  sfca_pkg::src_item_t src_data,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  sfca_pkg::dst_item_t dst_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_wdata,
    output int                  errors,
    output int                  pending,
    output int                  checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfca_pkg::*;

    logic [63:0] key_hi;
    logic [63:0] key_lo;
    dst_item_t   cipher_q[$];

    function automatic logic [7:0] gdbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic dst_item_t encrypt_frame(input src_item_t req, input logic [63:0] khi,
                                               input logic [63:0] klo);
        logic [7:0] fr[16];
        logic [7:0] rk[176];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] tw[4];
        logic [7:0] rc;
        logic [7:0] crc;
        logic [7:0] f;
        logic [7:0] a0, a1, a2, a3, al;
        dst_item_t  res;
        for (int i = 0; i < 16; i++)
            fr[i] = 8'h00;
        fr[0] = {4'h0, req.channel} + 8'h01;
        fr[1] = 8'h02;
        fr[2] = req.sample[15:8];
        fr[3] = req.sample[7:0];
        crc = 8'h00;
        for (int i = 0; i < 4; i++)
        begin
            crc = crc ^ fr[i];
            for (int b = 0; b < 8; b++)
                crc = crc[7] ? ({crc[6:0], 1'b0} ^ 8'h07) : {crc[6:0], 1'b0};
        end
        fr[4] = crc;
        for (int i = 0; i < 8; i++)
        begin
            rk[i] = khi[63-8*i -: 8];
            rk[8+i] = klo[63-8*i -: 8];
        end
        rc = 8'h01;
        for (int w = 4; w < 44; w++)
        begin
            for (int j = 0; j < 4; j++)
                tw[j] = rk[4*(w-1)+j];
            if ((w % 4) == 0)
            begin
                f = tw[0];
                tw[0] = SBOX[tw[1]] ^ rc;
                tw[1] = SBOX[tw[2]];
                tw[2] = SBOX[tw[3]];
                tw[3] = SBOX[f];
                rc = gdbl(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[4*w+j] = rk[4*(w-4)+j] ^ tw[j];
        end
        for (int i = 0; i < 16; i++)
            s[i] = fr[i] ^ rk[i];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[row+4*c] = SBOX[s[row+4*((c+row)%4)]];
            if (r != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gdbl(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gdbl(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gdbl(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gdbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 8; i++)
        begin
            res.cipher_upper[63-8*i -: 8] = s[i];
            res.cipher_lower[63-8*i -: 8] = s[8+i];
        end
        return res;
    endfunction

    assign pending = cipher_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        dst_item_t exp_c;
        int        nerr;
        nerr = 0;
        if (!rst_n)
        begin
            key_hi <= KeyUpperReset;
            key_lo <= KeyLowerReset;
            errors <= 0;
            checked <= 0;
            cipher_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CfgKeyUpper)
                    key_hi <= cfg_wdata;
                else
                    key_lo <= cfg_wdata;
            end
            if (src_valid && !src_stall)
                cipher_q.push_back(encrypt_frame(src_data, key_hi, key_lo));
            if (dst_valid && !dst_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    $display("%0t unexpected result: actual %h", $time, dst_data);
                    nerr = nerr + 1;
                end
                else
                begin
                    exp_c = cipher_q.pop_front();
                    checked <= checked + 1;
                    if (exp_c.cipher_upper !== dst_data.cipher_upper)
                    begin
                        $display("%0t cipher_upper: expected %h actual %h", $time,
                                 exp_c.cipher_upper, dst_data.cipher_upper);
                        nerr = nerr + 1;
                    end
                    if (exp_c.cipher_lower !== dst_data.cipher_lower)
                    begin
                        $display("%0t cipher_lower: expected %h actual %h", $time,
                                 exp_c.cipher_lower, dst_data.cipher_lower);
                        nerr = nerr + 1;
                    end
                end
            end
            if (nerr != 0)
                errors <= errors + nerr;
        end
    end
endmodule

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfca_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    src_item_t   src_data;
    logic        dst_valid;
    logic        dst_stall;
    dst_item_t   dst_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_wdata;
    int          errors;
    int          pending;
    int          checked;
    bit          hold_off;
    bit          random_stall;

    sample_framer_crc8_aes128_top dut (.*);

    sfca_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // receiver stall; long hold-off driven by the hold_off flag
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_stall <= 1'b0;
        else if (hold_off)
            dst_stall <= 1'b1;
        else if (random_stall)
            dst_stall <= ($urandom_range(0, 9) < 3) || ($urandom_range(0, 49) == 0);
        else
            dst_stall <= 1'b0;
    end

    // leaves src_valid high on return; drain() or a gap before the next request drops it
    task automatic send_request(input logic [3:0] ch, input logic [15:0] smp);
        int g;
        g = random_stall ? gap_len() : 0;
        if (g > 0)
        begin
            src_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= '{channel: ch, sample: smp};
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
            send_request(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        logic [63:0] kh, kl;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_data = '0;
        cfg_we = 1'b0;
        cfg_index = CfgKeyUpper;
        cfg_wdata = '0;
        hold_off = 1'b0;
        random_stall = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key, field extremes, all channels including above 8
        for (int c = 0; c < 16; c++)
            send_request(c[3:0], (c % 2) ? 16'hFFFF : 16'h0000);
        send_request(4'd8, 16'h8000);
        send_request(4'd0, 16'h0001);
        send_request(4'd15, 16'h00FF);
        send_request(4'd9, 16'hFF00);
        drain();

        random_stall = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin kh = '0; kl = '0; end
                1: begin kh = '1; kl = '1; end
                2: begin kh = '0; kl = '1; end
                default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
            endcase
            write_key(CfgKeyUpper, kh);
            write_key(CfgKeyLower, kl);
            if (ph == 3)
            begin
                // receiver holds off while sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (80) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    random_run(60);
                join
            end
            random_run(190);
            drain();
        end

        $display("Covered %0d requests over 7 key settings, all channels 0-15,", checked);
        $display("random gaps and stalls including a long receiver hold-off.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[filelist.f]
src/sfca_pkg.sv
src/sfca_round.sv
src/sample_framer_crc8_aes128_top.sv
test/sfca_checker.sv
test/testbench.sv
